/* rtl/core/bsst_pkg.sv */
// Shared constants and types for the sorted-table binary search unit.
package bsst_pkg;

   localparam int DEPTH_DEFAULT = 1024;

   localparam int VALUE_W = 32;
   localparam int CMD_W   = 2;
   localparam int POS_W   = 10;

   // Padded to whole bytes on the stream buses.
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

endpackage

/* rtl/core/bsst_ram.sv */
// Generic simple dual-port RAM, one write port and one registered read port.
module bsst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/bsst_ctrl.sv */
// Command sequencer: table fill count, interval registers, shared probe compare.
module bsst_ctrl import bsst_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [CMD_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  ram_wr_en,
   output logic [AW-1:0]         ram_wr_addr,
   output logic [VALUE_W-1:0]    ram_wr_data,
   output logic [AW-1:0]         ram_rd_addr,
   input  logic [VALUE_W-1:0]    ram_rd_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CMP,
      ST_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       lo_ff, lo_in;
   logic [CW-1:0]       hi1_ff, hi1_in;   // exclusive upper bound (right + 1)
   logic [AW-1:0]       mid_ff, mid_in;
   logic [VALUE_W-1:0]  key_ff, key_in;
   logic                found_ff, found_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;

   logic                accept;
   logic [CW-1:0]       span;
   logic [CW-1:0]       mid_full;
   logic                entry_gt, entry_lt;
   logic [AW+POS_W-1:0] mid_ext;

   assign accept = req_tvalid && req_tready;

   // Midpoint of [lo, hi1-1], rounded down; only used while lo < hi1.
   assign span     = hi1_ff - lo_ff - CW'(1);
   assign mid_full = lo_ff + (span >> 1);

   assign entry_gt = $signed(ram_rd_data) > $signed(key_ff);
   assign entry_lt = $signed(ram_rd_data) < $signed(key_ff);
   assign mid_ext  = {{POS_W{1'b0}}, mid_ff};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi1_in       = hi1_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = count_ff[AW-1:0];
      ram_wr_data  = req_tdata[VALUE_W-1:0];
      ram_rd_addr  = mid_full[AW-1:0];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  CMD_APPEND: begin
                     if (count_ff < CW'(DEPTH)) begin
                        ram_wr_en = 1'b1;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  CMD_SEARCH: begin
                     key_in   = req_tdata[VALUE_W-1:0];
                     lo_in    = '0;
                     hi1_in   = count_ff;
                     state_in = ST_PROBE;
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PROBE: begin
            if (lo_ff < hi1_ff) begin
               mid_in   = mid_full[AW-1:0];
               state_in = ST_CMP;
            end else begin
               found_in = 1'b0;
               pos_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_CMP: begin
            if (entry_gt) begin
               hi1_in   = CW'(mid_ff);
               state_in = ST_PROBE;
            end else if (entry_lt) begin
               lo_in    = CW'(mid_ff) + CW'(1);
               state_in = ST_PROBE;
            end else begin
               found_in = 1'b1;
               pos_in   = mid_ext[POS_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the output word register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_pos_in   = pos_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff        <= lo_in;
      hi1_ff       <= hi1_in;
      mid_ff       <= mid_in;
      key_ff       <= key_in;
      found_ff     <= found_in;
      pos_ff       <= pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - POS_W){1'b0}}, rsp_pos_ff};

endmodule

/* rtl/core/binary_search_sorted_table_unit.sv */
// Top level of the sorted-table binary search unit: sequencer plus table RAM.
//
//   channel  dir  tdata                      tuser
//   req      in   [31:0] value               [1:0] cmd (append/search/clear)
//   rsp      out  [9:0] position, [15:10] 0  [0] found
//
// Append, clear and unused codes complete in the idle state, without leaving it.
// A search with P probes (at most log2(DEPTH)+1) holds the input off until done;
// a miss ends when the probe state sees an empty interval. Each probe addresses
// the table RAM in the probe state and compares its registered read in ST_CMP.
// Reset empties the table at once (fill count to zero); no clearing pass.
// A finished search waits while the result register still holds a word.
module binary_search_sorted_table_unit import bsst_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [31:0] value
   input  logic [CMD_W-1:0]      req_tuser,   // [1:0] cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [9:0] position, [15:10] zero
   output logic                  rsp_tuser    // [0] found
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [VALUE_W-1:0] ram_wr_data;
   logic [AW-1:0]      ram_rd_addr;
   logic [VALUE_W-1:0] ram_rd_data;

   bsst_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   bsst_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
